>>> hdl/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image sampler.
// ----------------------------------------------------------------------------
package bis_pkg;

	// image store geometry
	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int LIM_MAX  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LIM_W    = $clog2(LIM_MAX + 1);

	// reset values of the clamp limits, already reduced to the store size
	localparam int ROWS_RST = (256 > MAX_ROWS) ? MAX_ROWS : 256;
	localparam int COLS_RST = (256 > MAX_COLS) ? MAX_COLS : 256;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

	// item opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// arithmetic widths
	localparam int COORD_W = 20;
	localparam int FRAC_W  = 8;
	localparam int IDX_W   = COORD_W - FRAC_W;
	localparam int PIX_W   = 8;
	localparam int NCH     = 3;
	localparam int PX_W    = PIX_W * NCH;
	localparam int OUT_W   = 16;
	localparam int TOP_W   = 29;
	localparam int DIFF_W  = TOP_W + 1;
	localparam int V_W     = 51;

	// front to back queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int LVL_W   = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic                      opcode;
		logic [7:0]                pixel_row;
		logic [7:0]                pixel_col;
		logic [7:0]                pixel_ch0;
		logic [7:0]                pixel_ch1;
		logic [7:0]                pixel_ch2;
		logic signed [COORD_W-1:0] sample_x;
		logic signed [COORD_W-1:0] sample_y;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0] sampled_ch0;
		logic [OUT_W-1:0] sampled_ch1;
		logic [OUT_W-1:0] sampled_ch2;
	} result_t;

	// classified item as it travels from front to back
	typedef struct packed {
		logic                      sample;
		logic                      wr_en;
		logic [ADDR_W-1:0]         wr_addr;
		logic [PX_W-1:0]           wr_pix;
		logic [ADDR_W-1:0]         a00;
		logic [ADDR_W-1:0]         a01;
		logic [ADDR_W-1:0]         a10;
		logic [ADDR_W-1:0]         a11;
		logic signed [COORD_W-1:0] tr;
		logic signed [COORD_W-1:0] tc;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} q_xfer_t;

endpackage

>>> hdl/bis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_front
// Accepts items, holds the clamp limits, and turns a sample into four store
// addresses and two weights; pixel writes become a store address and data.
// ----------------------------------------------------------------------------
module bis_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  bis_pkg::cmd_t                        cmd,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [bis_pkg::LVL_W-1:0]            q_level,
	output bis_pkg::q_xfer_t                     push
);

	localparam int COORD_W = bis_pkg::COORD_W;
	localparam int FRAC_W  = bis_pkg::FRAC_W;
	localparam int EXT_W   = COORD_W + 1;
	localparam int IDX_W   = bis_pkg::IDX_W;
	localparam int LIM_W   = bis_pkg::LIM_W;
	localparam int ROW_W   = bis_pkg::ROW_W;
	localparam int COL_W   = bis_pkg::COL_W;
	localparam int ADDR_W  = bis_pkg::ADDR_W;
	localparam int CMP_W   = (IDX_W > LIM_W) ? IDX_W : LIM_W;
	localparam int CNT_W   = bis_pkg::LVL_W + 1;

	logic [LIM_W-1:0]          rows_lim_q;
	logic [LIM_W-1:0]          cols_lim_q;
	logic                      vld_s1;
	bis_pkg::qentry_t          ent_s1;
	bis_pkg::qentry_t          ent_c;
	logic                      accept;
	logic [EXT_W-1:0]          y0_ext;
	logic [EXT_W-1:0]          y1_ext;
	logic [EXT_W-1:0]          x0_ext;
	logic [EXT_W-1:0]          x1_ext;
	logic [ROW_W-1:0]          r0;
	logic [ROW_W-1:0]          r1;
	logic [COL_W-1:0]          c0;
	logic [COL_W-1:0]          c1;
	logic [EXT_W-1:0]          tr_ext;
	logic [EXT_W-1:0]          tc_ext;

	// register value 0 acts as 1, anything above the store size as the size
	function automatic logic [LIM_W-1:0] eff_limit(logic [bis_pkg::CFG_DATA_W-1:0] v,
		int maxv);
		if (v == '0)
			return LIM_W'(1);
		if (int'(v) > maxv)
			return LIM_W'(maxv);
		return LIM_W'(v);
	endfunction

	// truncation toward zero, negative results clamp to 0 anyway
	function automatic logic [IDX_W-1:0] floor_idx(logic [EXT_W-1:0] v);
		if (v[EXT_W-1])
			return '0;
		return v[COORD_W-1:FRAC_W];
	endfunction

	function automatic logic [IDX_W-1:0] clamp_hi(logic [IDX_W-1:0] a, logic [LIM_W-1:0] lim);
		logic [CMP_W-1:0] ae;
		logic [CMP_W-1:0] le;
		ae = CMP_W'(a);
		le = CMP_W'(lim);
		if (ae >= le)
			ae = le - CMP_W'(1);
		return IDX_W'(ae);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(int unsigned r, int unsigned c);
		return ADDR_W'(r * bis_pkg::MAX_COLS + c);
	endfunction

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// hold off only when queue plus the item in flight could overrun it
	assign busy = (CNT_W'(q_level) + CNT_W'(vld_s1)) >= CNT_W'(bis_pkg::Q_DEPTH);

	// clamp limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_lim_q <= LIM_W'(bis_pkg::ROWS_RST);
			cols_lim_q <= LIM_W'(bis_pkg::COLS_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bis_pkg::CFG_IMAGE_ROWS: rows_lim_q <= eff_limit(cfg_data, bis_pkg::MAX_ROWS);
				bis_pkg::CFG_IMAGE_COLS: cols_lim_q <= eff_limit(cfg_data, bis_pkg::MAX_COLS);
				default: ;
			endcase
		end
	end

	// classify the item and work out indices and weights
	always_comb begin
		y0_ext = {cmd.sample_y[COORD_W-1], cmd.sample_y};
		x0_ext = {cmd.sample_x[COORD_W-1], cmd.sample_x};
		y1_ext = y0_ext + EXT_W'(256);
		x1_ext = x0_ext + EXT_W'(256);

		r0 = ROW_W'(clamp_hi(floor_idx(y0_ext), rows_lim_q));
		r1 = ROW_W'(clamp_hi(floor_idx(y1_ext), rows_lim_q));
		c0 = COL_W'(clamp_hi(floor_idx(x0_ext), cols_lim_q));
		c1 = COL_W'(clamp_hi(floor_idx(x1_ext), cols_lim_q));

		// weight relative to the clamped base; always fits the coordinate width
		tr_ext = y0_ext - (EXT_W'(r0) << FRAC_W);
		tc_ext = x0_ext - (EXT_W'(c0) << FRAC_W);

		ent_c.sample  = (cmd.opcode == bis_pkg::OP_SAMPLE);
		ent_c.wr_en   = (int'(cmd.pixel_row) < bis_pkg::MAX_ROWS) &&
		                (int'(cmd.pixel_col) < bis_pkg::MAX_COLS);
		ent_c.wr_addr = addr_of(int'(cmd.pixel_row), int'(cmd.pixel_col));
		ent_c.wr_pix  = {cmd.pixel_ch2, cmd.pixel_ch1, cmd.pixel_ch0};
		ent_c.a00     = addr_of(int'(r0), int'(c0));
		ent_c.a01     = addr_of(int'(r0), int'(c1));
		ent_c.a10     = addr_of(int'(r1), int'(c0));
		ent_c.a11     = addr_of(int'(r1), int'(c1));
		ent_c.tr      = $signed(tr_ext[COORD_W-1:0]);
		ent_c.tc      = $signed(tc_ext[COORD_W-1:0]);
	end

	// front pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept)
			ent_s1 <= ent_c;
	end

	assign push.valid = vld_s1;
	assign push.entry = ent_s1;

endmodule

>>> hdl/bis_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_queue
// Short in-order queue between front and back; the back drains one item
// per cycle whenever the queue holds one.
// ----------------------------------------------------------------------------
module bis_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bis_pkg::q_xfer_t              push,
	output bis_pkg::q_xfer_t              head,
	output logic [bis_pkg::LVL_W-1:0]     level
);

	localparam int Q_DEPTH = bis_pkg::Q_DEPTH;
	localparam int Q_PTR_W = bis_pkg::Q_PTR_W;
	localparam int LVL_W   = bis_pkg::LVL_W;

	bis_pkg::qentry_t     ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [LVL_W-1:0]     level_q;
	logic                 pop;

	assign pop        = (level_q != '0);
	assign head.valid = pop;
	assign head.entry = ent_q[rd_ptr_q];
	assign level      = level_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			case ({push.valid, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid)
			ent_q[wr_ptr_q] <= push.entry;
	end

endmodule

>>> hdl/bis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_back
// Image store (four copies, one read port each) and the blend pipeline:
// read, horizontal blend, difference, vertical product, round and saturate.
// ----------------------------------------------------------------------------
module bis_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bis_pkg::q_xfer_t       head,
	output logic                   done,
	output bis_pkg::result_t       result
);

	localparam int DEPTH   = bis_pkg::DEPTH;
	localparam int PX_W    = bis_pkg::PX_W;
	localparam int PIX_W   = bis_pkg::PIX_W;
	localparam int NCH     = bis_pkg::NCH;
	localparam int COORD_W = bis_pkg::COORD_W;
	localparam int FRAC_W  = bis_pkg::FRAC_W;
	localparam int TOP_W   = bis_pkg::TOP_W;
	localparam int DIFF_W  = bis_pkg::DIFF_W;
	localparam int V_W     = bis_pkg::V_W;
	localparam int OUT_W   = bis_pkg::OUT_W;

	logic [PX_W-1:0] mem00 [DEPTH];
	logic [PX_W-1:0] mem01 [DEPTH];
	logic [PX_W-1:0] mem10 [DEPTH];
	logic [PX_W-1:0] mem11 [DEPTH];

	logic                      wr;
	logic                      rd;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PX_W-1:0]           q00_s1, q01_s1, q10_s1, q11_s1;
	logic signed [COORD_W-1:0] tr_s1, tc_s1, tr_s2, tr_s3;
	logic signed [TOP_W-1:0]   top_c [NCH];
	logic signed [TOP_W-1:0]   bot_c [NCH];
	logic signed [TOP_W-1:0]   top_s2 [NCH];
	logic signed [TOP_W-1:0]   bot_s2 [NCH];
	logic signed [TOP_W-1:0]   top_s3 [NCH];
	logic signed [TOP_W-1:0]   top_s4 [NCH];
	logic signed [DIFF_W-1:0]  diff_s3 [NCH];
	logic signed [V_W-1:0]     prod_s4 [NCH];
	logic signed [V_W-1:0]     v_c [NCH];
	logic [OUT_W-1:0]          sat_c [NCH];
	logic                      done_q;
	bis_pkg::result_t          result_q;

	assign wr = head.valid && !head.entry.sample && head.entry.wr_en;
	assign rd = head.valid && head.entry.sample;

	// store copies: every write goes to all four, each serves one corner
	always_ff @(posedge clk) begin
		if (wr)
			mem00[head.entry.wr_addr] <= head.entry.wr_pix;
		if (rd)
			q00_s1 <= mem00[head.entry.a00];
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem01[head.entry.wr_addr] <= head.entry.wr_pix;
		if (rd)
			q01_s1 <= mem01[head.entry.a01];
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem10[head.entry.wr_addr] <= head.entry.wr_pix;
		if (rd)
			q10_s1 <= mem10[head.entry.a10];
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem11[head.entry.wr_addr] <= head.entry.wr_pix;
		if (rd)
			q11_s1 <= mem11[head.entry.a11];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4;
		end
	end

	// horizontal blend: p0*256 + tc*(p1 - p0)
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			top_c[ch] = TOP_W'($signed({1'b0, q00_s1[ch*PIX_W +: PIX_W], FRAC_W'(0)})) +
			            TOP_W'(tc_s1) *
			            TOP_W'($signed({1'b0, q01_s1[ch*PIX_W +: PIX_W]}) -
			                   $signed({1'b0, q00_s1[ch*PIX_W +: PIX_W]}));
			bot_c[ch] = TOP_W'($signed({1'b0, q10_s1[ch*PIX_W +: PIX_W], FRAC_W'(0)})) +
			            TOP_W'(tc_s1) *
			            TOP_W'($signed({1'b0, q11_s1[ch*PIX_W +: PIX_W]}) -
			                   $signed({1'b0, q10_s1[ch*PIX_W +: PIX_W]}));
		end
	end

	// weights ride alongside the read
	always_ff @(posedge clk) begin
		if (rd) begin
			tr_s1 <= head.entry.tr;
			tc_s1 <= head.entry.tc;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		tr_s2 <= tr_s1;
		tr_s3 <= tr_s2;
		for (int ch = 0; ch < NCH; ch++) begin
			top_s2[ch]  <= top_c[ch];
			bot_s2[ch]  <= bot_c[ch];
			diff_s3[ch] <= DIFF_W'(bot_s2[ch]) - DIFF_W'(top_s2[ch]);
			top_s3[ch]  <= top_s2[ch];
			prod_s4[ch] <= V_W'(tr_s3) * V_W'(diff_s3[ch]);
			top_s4[ch]  <= top_s3[ch];
		end
	end

	// vertical sum, round half up, saturate to 8.8
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			v_c[ch] = (V_W'(top_s4[ch]) <<< FRAC_W) + prod_s4[ch] + V_W'(128);
			if (v_c[ch][V_W-1])
				sat_c[ch] = '0;
			else if (|v_c[ch][V_W-2:FRAC_W+OUT_W])
				sat_c[ch] = '1;
			else
				sat_c[ch] = v_c[ch][FRAC_W +: OUT_W];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (vld_s4) begin
			result_q.sampled_ch0 <= sat_c[0];
			result_q.sampled_ch1 <= sat_c[1];
			result_q.sampled_ch2 <= sat_c[2];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hdl/bilinear_image_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_sampler_core
// Bilinear sampler with edge clamp over a three-channel 8-bit image that is
// loaded by pixel-write items.
// ----------------------------------------------------------------------------
// Throughput: one item per clock; the four corner reads of a sample use four
// store copies, so samples and writes may follow each other every cycle.
// Result: done pulses for one cycle once a sample has passed its stages
// (front register, queue, store read, three blend stages, output register).
// Pixel writes give no result. The receiver cannot stall, so busy stays low.
// Reset clears control state and sets both clamp limits to 256; the image
// store is not cleared and holds garbage until its pixels are written.
module bilinear_image_sampler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  bis_pkg::cmd_t                      cmd,
	output logic                               done,
	output bis_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]     cfg_data
);

	bis_pkg::q_xfer_t              push;
	bis_pkg::q_xfer_t              head;
	logic [bis_pkg::LVL_W-1:0]     q_level;

	// accept and classify
	bis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_level   (q_level),
		.push      (push)
	);

	// decoupling queue
	bis_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.head   (head),
		.level  (q_level)
	);

	// store and blend
	bis_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.done   (done),
		.result (result)
	);

endmodule
